// ===== hw/rtl/psl_pkg.sv =====
`default_nettype none

package psl_pkg;

	// field widths of the request and response channels
	localparam int CMD_W     = 3;
	localparam int POS_W     = 8;
	localparam int SYM_W     = 8;
	localparam int OUT_POS_W = 7;

	// default number of symbol slots
	localparam int CAPACITY_DEF = 64;

	// request codes
	typedef enum logic [CMD_W-1:0] {
		CMD_CLEAR  = 3'd0,
		CMD_INSERT = 3'd1,
		CMD_DELETE = 3'd2,
		CMD_FIND   = 3'd3,
		CMD_READ   = 3'd4
	} cmd_t;

	// sequencer states
	typedef enum logic [2:0] {
		S_IDLE,
		S_ALLOC,
		S_WALK,
		S_AT_NODE,
		S_INS_LINK,
		S_DEL_Q,
		S_DEL_FREE,
		S_DONE
	} state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/psl_if.sv =====
`default_nettype none

// request channel
interface psl_req_if;
	import psl_pkg::*;

	logic             valid;
	logic             ready;
	logic [CMD_W-1:0] cmd;
	logic [POS_W-1:0] position;
	logic [SYM_W-1:0] symbol;

	modport source(output valid, cmd, position, symbol, input ready);
	modport sink(input valid, cmd, position, symbol, output ready);
endinterface

// response channel
interface psl_rsp_if;
	import psl_pkg::*;

	logic                 valid;
	logic                 ready;
	logic                 ok;
	logic [SYM_W-1:0]     symbol_out;
	logic [OUT_POS_W-1:0] position_out;
	logic [OUT_POS_W-1:0] list_length;

	modport source(output valid, ok, symbol_out, position_out, list_length, input ready);
	modport sink(input valid, ok, symbol_out, position_out, list_length, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/positional_symbol_list_top.sv =====
`default_nettype none

// Positional symbol list: an ordered list of up to CAPACITY byte symbols kept as a singly
// linked list in two synchronous memories (symbols and next links), with a free stack of
// released slots and a high-water mark for slots never used since the last clear, so clear
// takes constant time and no clearing pass is needed after reset. One request is in work at
// a time; the response sits in an output register so the next request is taken while it
// waits. Clear and rejected requests go straight to the response; a read, and an insert or
// delete past the front, walk the list to its position, and find walks until a match or the
// end of the list. The next request is taken in the cycle after the response is registered.
// The walk follows one link per cycle through the link memory read port.
module positional_symbol_list_top #(
	parameter int CAPACITY = psl_pkg::CAPACITY_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	psl_req_if.sink  req,
	psl_rsp_if.source rsp
);
	import psl_pkg::*;

	localparam int AW   = $clog2(CAPACITY);
	localparam int IW   = $clog2(CAPACITY + 1);
	localparam int CMPW = ((IW > POS_W) ? IW : POS_W) + 1;
	localparam logic [IW-1:0] NIL = IW'(CAPACITY);

	// control state
	state_t          state_q, state_d;
	logic [IW-1:0]   head_q, free_q, mark_q, count_q;
	logic            rsp_vld_q;

	// per-request working registers
	logic [CMD_W-1:0] cmd_q;
	logic [SYM_W-1:0] sym_q;
	logic [IW-1:0]    tgt_q, n_q, node_q, slot_q, q_q;
	logic             first_q, del_head_q;
	logic             have_s1;
	logic [IW-1:0]    pos_s1;
	logic             res_ok_q;
	logic [SYM_W-1:0] res_sym_q;
	logic [IW-1:0]    res_pos_q;

	// output register payload
	logic                 rsp_ok_q;
	logic [SYM_W-1:0]     rsp_sym_q;
	logic [OUT_POS_W-1:0] rsp_pos_q, rsp_len_q;

	// memory ports
	logic             rd_en;
	logic [AW-1:0]    rd_addr;
	logic             lwe, swe;
	logic [AW-1:0]    lwa, swa;
	logic [IW-1:0]    lwd;
	logic [SYM_W-1:0] swd;
	logic [IW-1:0]    link_rdata;
	logic [SYM_W-1:0] sym_rdata;

	// decode
	logic             accept, out_free;
	logic [CMPW-1:0]  pos_x, cnt_x;
	logic             rng_ok, ins_ok, pos_one;
	logic [IW-1:0]    walk_a, alloc_slot;
	logic             find_hit, at_tgt;

	assign accept   = req.valid && req.ready;
	assign out_free = !rsp_vld_q || rsp.ready;

	// range checks on the incoming position
	assign pos_x   = CMPW'(req.position);
	assign cnt_x   = CMPW'(count_q);
	assign rng_ok  = (pos_x != '0) && (pos_x <= cnt_x);
	assign ins_ok  = (pos_x != '0) && (pos_x <= cnt_x + CMPW'(1)) && (count_q != NIL);
	assign pos_one = (req.position == POS_W'(1));

	// walk pointer: head on the first step, then the link just read
	assign walk_a     = first_q ? head_q : link_rdata;
	assign find_hit   = have_s1 && (sym_rdata == sym_q);
	assign at_tgt     = (n_q == tgt_q);
	assign alloc_slot = (free_q != NIL) ? free_q : mark_q;

	psl_ram #(.DEPTH(CAPACITY), .WIDTH(IW)) u_link_ram (
		.clk   (clk),
		.we    (lwe),
		.waddr (lwa),
		.wdata (lwd),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (link_rdata)
	);

	psl_ram #(.DEPTH(CAPACITY), .WIDTH(SYM_W)) u_sym_ram (
		.clk   (clk),
		.we    (swe),
		.waddr (swa),
		.wdata (swd),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (sym_rdata)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (req.cmd)
						CMD_INSERT: state_d = ins_ok ? S_ALLOC : S_DONE;
						CMD_DELETE: state_d = !rng_ok ? S_DONE : (pos_one ? S_DEL_Q : S_WALK);
						CMD_FIND:   state_d = S_WALK;
						CMD_READ:   state_d = rng_ok ? S_WALK : S_DONE;
						default:    state_d = S_DONE;
					endcase
				end
			end
			S_ALLOC: begin
				state_d = (tgt_q == '0) ? S_DONE : S_WALK;
			end
			S_WALK: begin
				if (cmd_q == CMD_FIND) begin
					if (find_hit || walk_a == NIL) begin
						state_d = S_DONE;
					end
				end else if (at_tgt) begin
					state_d = S_AT_NODE;
				end
			end
			S_AT_NODE: begin
				case (cmd_q)
					CMD_INSERT: state_d = S_INS_LINK;
					CMD_DELETE: state_d = S_DEL_Q;
					default:    state_d = S_DONE;
				endcase
			end
			S_INS_LINK: state_d = S_DONE;
			S_DEL_Q:    state_d = S_DEL_FREE;
			S_DEL_FREE: state_d = S_DONE;
			S_DONE: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// handshake and memory controls
	always_comb begin
		req.ready = (state_q == S_IDLE);
		rd_en     = 1'b0;
		rd_addr   = '0;
		lwe       = 1'b0;
		lwa       = '0;
		lwd       = '0;
		swe       = 1'b0;
		swa       = '0;
		swd       = sym_q;
		case (state_q)
			S_IDLE: begin
				// prefetch the free stack link or the head node
				if (accept && req.cmd == CMD_INSERT && free_q != NIL) begin
					rd_en   = 1'b1;
					rd_addr = free_q[AW-1:0];
				end else if (accept && req.cmd == CMD_DELETE && rng_ok && pos_one) begin
					rd_en   = 1'b1;
					rd_addr = head_q[AW-1:0];
				end
			end
			S_ALLOC: begin
				swe = 1'b1;
				swa = alloc_slot[AW-1:0];
				if (tgt_q == '0) begin
					lwe = 1'b1;
					lwa = alloc_slot[AW-1:0];
					lwd = head_q;
				end
			end
			S_WALK: begin
				if (!(cmd_q == CMD_FIND && find_hit) && walk_a != NIL) begin
					rd_en   = 1'b1;
					rd_addr = walk_a[AW-1:0];
				end
			end
			S_AT_NODE: begin
				if (cmd_q == CMD_INSERT) begin
					lwe = 1'b1;
					lwa = slot_q[AW-1:0];
					lwd = link_rdata;
				end else if (cmd_q == CMD_DELETE) begin
					rd_en   = 1'b1;
					rd_addr = link_rdata[AW-1:0];
				end
			end
			S_INS_LINK: begin
				lwe = 1'b1;
				lwa = node_q[AW-1:0];
				lwd = slot_q;
			end
			S_DEL_Q: begin
				if (!del_head_q) begin
					lwe = 1'b1;
					lwa = node_q[AW-1:0];
					lwd = link_rdata;
				end
			end
			S_DEL_FREE: begin
				lwe = 1'b1;
				lwa = q_q[AW-1:0];
				lwd = free_q;
			end
			default: ;
		endcase
	end

	// list bookkeeping and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			head_q    <= NIL;
			free_q    <= NIL;
			mark_q    <= '0;
			count_q   <= '0;
			rsp_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				S_IDLE: begin
					if (accept && req.cmd == CMD_CLEAR) begin
						head_q  <= NIL;
						free_q  <= NIL;
						mark_q  <= '0;
						count_q <= '0;
					end
				end
				S_ALLOC: begin
					// pop the free stack, else take a never-used slot
					if (free_q != NIL) begin
						free_q <= link_rdata;
					end else begin
						mark_q <= mark_q + IW'(1);
					end
					if (tgt_q == '0) begin
						head_q  <= alloc_slot;
						count_q <= count_q + IW'(1);
					end
				end
				S_INS_LINK: count_q <= count_q + IW'(1);
				S_DEL_Q: begin
					if (del_head_q) begin
						head_q <= link_rdata;
					end
				end
				S_DEL_FREE: begin
					free_q  <= q_q;
					count_q <= count_q - IW'(1);
				end
				default: ;
			endcase
			if (state_q == S_DONE && out_free) begin
				rsp_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_vld_q <= 1'b0;
			end
		end
	end

	// per-request working registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					cmd_q      <= req.cmd;
					sym_q      <= req.symbol;
					first_q    <= 1'b1;
					have_s1    <= 1'b0;
					n_q        <= IW'(1);
					del_head_q <= pos_one;
					q_q        <= head_q;
					res_ok_q   <= (req.cmd == CMD_CLEAR);
					res_sym_q  <= '0;
					res_pos_q  <= '0;
					if (req.cmd == CMD_READ) begin
						tgt_q <= IW'(req.position);
					end else begin
						tgt_q <= IW'(req.position - POS_W'(1));
					end
				end
			end
			S_ALLOC: begin
				slot_q <= alloc_slot;
				if (tgt_q == '0) begin
					res_ok_q <= 1'b1;
				end
			end
			S_WALK: begin
				if (cmd_q == CMD_FIND) begin
					if (find_hit) begin
						res_ok_q  <= 1'b1;
						res_pos_q <= pos_s1;
					end else if (walk_a != NIL) begin
						have_s1 <= 1'b1;
						pos_s1  <= n_q;
						n_q     <= n_q + IW'(1);
						first_q <= 1'b0;
					end
				end else if (at_tgt) begin
					node_q <= walk_a;
				end else begin
					n_q     <= n_q + IW'(1);
					first_q <= 1'b0;
				end
			end
			S_AT_NODE: begin
				if (cmd_q == CMD_DELETE) begin
					q_q <= link_rdata;
				end else if (cmd_q == CMD_READ) begin
					res_ok_q  <= 1'b1;
					res_sym_q <= sym_rdata;
				end
			end
			S_INS_LINK: res_ok_q <= 1'b1;
			S_DEL_Q:    res_sym_q <= sym_rdata;
			S_DEL_FREE: res_ok_q <= 1'b1;
			default: ;
		endcase
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			rsp_ok_q  <= res_ok_q;
			rsp_sym_q <= res_sym_q;
			rsp_pos_q <= OUT_POS_W'(res_pos_q);
			rsp_len_q <= OUT_POS_W'(count_q);
		end
	end

	assign rsp.valid        = rsp_vld_q;
	assign rsp.ok           = rsp_ok_q;
	assign rsp.symbol_out   = rsp_sym_q;
	assign rsp.position_out = rsp_pos_q;
	assign rsp.list_length  = rsp_len_q;

	// checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= NIL)
		else $error("symbol count above capacity");

	a_mark_cover: assert property (@(posedge clk) disable iff (!arst_n)
		mark_q >= count_q)
		else $error("more symbols held than slots ever handed out");

	// head and count settle together once a request is finished
	a_empty_head: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> ((count_q == '0) == (head_q == NIL)))
		else $error("head pointer disagrees with symbol count");

	a_clear_done: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && req.cmd == CMD_CLEAR) |=>
			(state_q == S_DONE && res_ok_q && count_q == '0 && head_q == NIL))
		else $error("clear did not empty the list");

endmodule

`default_nettype wire

// ===== hw/rtl/psl_ram.sv =====
`default_nettype none

// single-port-write, single-port-read memory with registered read data
module psl_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 8
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire
